FILE: hw/rtl/u8js_pkg.sv
// Package for the UTF-8 to JSON string escaper.
// Types, codes and constants shared by the decoder, emitter and top level.
// No dependencies.
package u8js_pkg;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LEAD     = 3'd1,
    ERR_CONT     = 3'd2,
    ERR_OVERLONG = 3'd3,
    ERR_RANGE    = 3'd4,
    ERR_TRUNC    = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    CK_PLAIN = 2'd0,
    CK_ESC   = 2'd1,
    CK_HEX   = 2'd2,
    CK_SURR  = 2'd3
  } char_kind_e;

  // Result groups of one word, in output order.
  localparam int unsigned GRP_OPEN_ERR  = 0;
  localparam int unsigned GRP_OPEN_Q    = 1;
  localparam int unsigned GRP_ERR_CONT  = 2;
  localparam int unsigned GRP_ERR_MID   = 3;
  localparam int unsigned GRP_CHAR      = 4;
  localparam int unsigned GRP_CLOSE_ERR = 5;
  localparam int unsigned GRP_CLOSE_Q   = 6;
  localparam int unsigned NumGroups     = 7;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChU         = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;

  localparam logic [20:0] CodeMin3     = 21'h000800;
  localparam logic [20:0] CodeMin4     = 21'h010000;
  localparam logic [20:0] CodeMax      = 21'h10ffff;
  localparam logic [20:0] SurrFirst    = 21'h00d800;
  localparam logic [20:0] SurrEnd      = 21'h00e000;
  localparam logic [20:0] CodeCtrlMax  = 21'h00001f;
  localparam logic [20:0] CodeDel      = 21'h00007f;
  localparam logic [5:0]  SurrHiPrefix = 6'b110110;
  localparam logic [5:0]  SurrLoPrefix = 6'b110111;

  localparam logic [7:0] LeadMin2 = 8'hc2;
  localparam logic [7:0] LeadMin3 = 8'he0;
  localparam logic [7:0] LeadMin4 = 8'hf0;
  localparam logic [7:0] LeadEnd  = 8'hf5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       first_of_string;
    logic       last_of_string;
  } item_t;

  typedef struct packed {
    logic [20:0] part;
    logic [1:0]  rem;
    logic [1:0]  slen;
  } dec_state_t;

  typedef struct packed {
    logic [NumGroups-1:0] grp;
    err_e                 mid_err;
    char_kind_e           kind;
    logic [15:0]          hex_a;
    logic [15:0]          hex_b;
  } plan_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } emit_stat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = ChZero + {4'd0, n};
    end else begin
      d = ChLowerA + {4'd0, n} - 8'd10;
    end
    return d;
  endfunction

endpackage

FILE: hw/rtl/u8js_in_if.sv
// Input channel of the escaper: one UTF-8 byte word with string markers.
// No dependencies.
interface u8js_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       first_of_string;
  logic       last_of_string;

  modport source (output valid, in_byte, has_byte, first_of_string, last_of_string,
                  input ready);
  modport sink (input valid, in_byte, has_byte, first_of_string, last_of_string,
                output ready);
endinterface

FILE: hw/rtl/u8js_out_if.sv
// Output channel of the escaper: one JSON literal byte or error report per word.
// No dependencies.
interface u8js_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, out_byte, byte_valid, error_code, last_of_run,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, error_code, last_of_run,
                output ready);
endinterface

FILE: hw/rtl/utf8_to_json_string_escaper_core.sv
// Escaper top level: input register, UTF-8 decode state, emitter.
// Depends on u8js_pkg, u8js_in_if, u8js_out_if, u8js_decode, u8js_emit.
//
// Takes one UTF-8 byte word per cycle when not stalled and produces the
// quoted JSON literal, one output word per cycle while the receiver is ready.
// A word flows input register -> decode into a plan register -> output
// register. The single output port sets the rate: a word that yields n
// results (1 to 13) holds the emitter until all n are presented, and a word
// that yields none does not hold it. Words that each give one result stream
// at one per cycle while the receiver is ready; escapes stall the input
// through ready.
module utf8_to_json_string_escaper_core
  import u8js_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  u8js_in_if.sink   in_i,
  u8js_out_if.source out_o
);

  item_t      in_q;
  logic       in_vld_q;
  dec_state_t st_q;
  dec_state_t st_d;
  plan_t      plan;
  emit_stat_t stat;
  logic       take;
  logic       accept;

  assign take       = in_vld_q && (!stat.busy || stat.finish);
  assign in_i.ready = !in_vld_q || take;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (take) begin
        in_vld_q <= 1'b0;
      end
      if (take) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= '{in_byte: in_i.in_byte, has_byte: in_i.has_byte,
                first_of_string: in_i.first_of_string,
                last_of_string: in_i.last_of_string};
    end
  end

  u8js_decode u_decode (
    .item_i (in_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .plan_o (plan)
  );

  u8js_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .plan_i   (plan),
    .load_i   (take),
    .status_o (stat),
    .out_o    (out_o)
  );

  // pending sequence state stays consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.rem <= st_q.slen && (st_q.rem != 2'd0 || st_q.slen == 2'd0))
    else $error("decode state inconsistent");

  // a finished plan that is not replaced leaves the emitter idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.finish && !take |=> !stat.busy)
    else $error("emitter busy after finishing");

  // an idle input register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_i.ready)
    else $error("input stalled while empty");

  // a word carries text or an error, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_valid == (out_o.error_code == ERR_NONE)))
    else $error("text and error in one word");

endmodule

FILE: hw/rtl/u8js_decode.sv
// UTF-8 decode step: turns one input word and the pending sequence state into
// an output plan and the next state. Combinational. Depends on u8js_pkg.
module u8js_decode
  import u8js_pkg::*;
(
  input  item_t      item_i,
  input  dec_state_t st_i,
  output dec_state_t st_o,
  output plan_t      plan_o
);

  logic        do_lead;
  logic        do_char;
  logic [20:0] code;
  logic [20:0] acc;
  logic [20:0] sv;
  logic [7:0]  b;

  assign b = item_i.in_byte;

  always_comb begin
    plan_o         = '0;
    plan_o.mid_err = ERR_NONE;
    plan_o.kind    = CK_PLAIN;
    st_o           = st_i;
    do_lead        = 1'b0;
    do_char        = 1'b0;
    code           = '0;
    acc            = {st_i.part[14:0], b[5:0]};
    sv             = '0;

    if (item_i.first_of_string) begin
      if (st_o.rem != 2'd0) begin
        plan_o.grp[GRP_OPEN_ERR] = 1'b1;
      end
      st_o                   = '0;
      plan_o.grp[GRP_OPEN_Q] = 1'b1;
    end

    if (item_i.has_byte) begin
      if (st_o.rem == 2'd0) begin
        do_lead = 1'b1;
      end else if (b[7:6] != 2'b10) begin
        plan_o.grp[GRP_ERR_CONT] = 1'b1;
        st_o                     = '0;
        do_lead                  = 1'b1;
      end else begin
        st_o.part = acc;
        st_o.rem  = st_o.rem - 2'd1;
        if (st_o.rem == 2'd0) begin
          if ((st_o.slen == 2'd2 && acc < CodeMin3) ||
              (st_o.slen == 2'd3 && acc < CodeMin4)) begin
            plan_o.mid_err = ERR_OVERLONG;
          end else if (acc > CodeMax || (acc >= SurrFirst && acc < SurrEnd)) begin
            plan_o.mid_err = ERR_RANGE;
          end else begin
            do_char = 1'b1;
            code    = acc;
          end
          st_o = '0;
        end
      end

      if (do_lead) begin
        if (!b[7]) begin
          do_char = 1'b1;
          code    = {13'd0, b};
        end else if (b < LeadMin2 || b >= LeadEnd) begin
          plan_o.mid_err = ERR_LEAD;
        end else if (b < LeadMin3) begin
          st_o = '{part: {16'd0, b[4:0]}, rem: 2'd1, slen: 2'd1};
        end else if (b < LeadMin4) begin
          st_o = '{part: {17'd0, b[3:0]}, rem: 2'd2, slen: 2'd2};
        end else begin
          st_o = '{part: {18'd0, b[2:0]}, rem: 2'd3, slen: 2'd3};
        end
      end
    end

    if (plan_o.mid_err != ERR_NONE) begin
      plan_o.grp[GRP_ERR_MID] = 1'b1;
    end

    if (do_char) begin
      plan_o.grp[GRP_CHAR] = 1'b1;
      plan_o.hex_a         = code[15:0];
      if (code >= CodeMin4) begin
        sv           = code - CodeMin4;
        plan_o.kind  = CK_SURR;
        plan_o.hex_a = {SurrHiPrefix, sv[19:10]};
        plan_o.hex_b = {SurrLoPrefix, code[9:0]};
      end else if (code[7:0] == ChQuote && code[20:8] == '0 ||
                   code[7:0] == ChBackslash && code[20:8] == '0) begin
        plan_o.kind = CK_ESC;
      end else if (code <= CodeCtrlMax || code >= CodeDel) begin
        plan_o.kind = CK_HEX;
      end else begin
        plan_o.kind = CK_PLAIN;
      end
    end

    if (item_i.last_of_string) begin
      if (st_o.rem != 2'd0) begin
        plan_o.grp[GRP_CLOSE_ERR] = 1'b1;
      end
      st_o                    = '0;
      plan_o.grp[GRP_CLOSE_Q] = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/u8js_emit.sv
// Result emitter: walks one plan, one output word per cycle while the receiver
// is ready, into the output register. Depends on u8js_pkg and u8js_out_if.
module u8js_emit
  import u8js_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  plan_t      plan_i,
  input  logic       load_i,
  output emit_stat_t status_o,
  u8js_out_if.source out_o
);

  plan_t                plan_q;
  logic                 plan_vld_q;
  logic [3:0]           c_q;
  logic                 out_vld_q;
  logic [7:0]           byte_q;
  logic                 bvld_q;
  err_e                 err_q;
  logic                 last_q;

  logic [NumGroups-1:0] cur_oh;
  logic                 char_done;
  logic                 grp_last;
  logic                 go;
  logic                 last;
  logic [3:0]           last_idx;
  logic                 sel_b;
  logic [2:0]           pos;
  logic [15:0]          word;
  logic [7:0]           hex_byte;
  logic [7:0]           char_byte;
  logic [7:0]           byte_d;
  logic                 bvld_d;
  err_e                 err_d;

  always_comb begin
    cur_oh = plan_q.grp & (~plan_q.grp + 7'd1);
    case (plan_q.kind)
      CK_PLAIN: last_idx = 4'd0;
      CK_ESC:   last_idx = 4'd1;
      CK_HEX:   last_idx = 4'd5;
      CK_SURR:  last_idx = 4'd11;
      default:  last_idx = 4'd0;
    endcase
    char_done = !cur_oh[GRP_CHAR] || (c_q == last_idx);
    grp_last  = (plan_q.grp & ~cur_oh) == '0;
    go        = plan_vld_q && (!out_vld_q || out_o.ready);
    last      = grp_last && char_done;

    sel_b = c_q >= 4'd6;
    pos   = sel_b ? 3'(c_q - 4'd6) : c_q[2:0];
    word  = sel_b ? plan_q.hex_b : plan_q.hex_a;
    case (pos)
      3'd0:    hex_byte = ChBackslash;
      3'd1:    hex_byte = ChU;
      3'd2:    hex_byte = hex_digit(word[15:12]);
      3'd3:    hex_byte = hex_digit(word[11:8]);
      3'd4:    hex_byte = hex_digit(word[7:4]);
      3'd5:    hex_byte = hex_digit(word[3:0]);
      default: hex_byte = ChBackslash;
    endcase
    case (plan_q.kind)
      CK_PLAIN: char_byte = plan_q.hex_a[7:0];
      CK_ESC:   char_byte = (c_q == 4'd0) ? ChBackslash : plan_q.hex_a[7:0];
      default:  char_byte = hex_byte;
    endcase

    byte_d = '0;
    bvld_d = 1'b0;
    err_d  = ERR_NONE;
    if (cur_oh[GRP_OPEN_ERR] || cur_oh[GRP_CLOSE_ERR]) begin
      err_d = ERR_TRUNC;
    end else if (cur_oh[GRP_OPEN_Q] || cur_oh[GRP_CLOSE_Q]) begin
      byte_d = ChQuote;
      bvld_d = 1'b1;
    end else if (cur_oh[GRP_ERR_CONT]) begin
      err_d = ERR_CONT;
    end else if (cur_oh[GRP_ERR_MID]) begin
      err_d = plan_q.mid_err;
    end else if (cur_oh[GRP_CHAR]) begin
      byte_d = char_byte;
      bvld_d = 1'b1;
    end
  end

  assign status_o.busy   = plan_vld_q;
  assign status_o.finish = go && last;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      plan_q <= plan_i;
    end else if (go && char_done) begin
      plan_q.grp <= plan_q.grp & ~cur_oh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_vld_q <= 1'b0;
      c_q        <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load_i) begin
        plan_vld_q <= |plan_i.grp;
        c_q        <= '0;
      end else if (go) begin
        if (last) begin
          plan_vld_q <= 1'b0;
        end
        c_q <= char_done ? 4'd0 : c_q + 4'd1;
      end
      if (go) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      byte_q <= byte_d;
      bvld_q <= bvld_d;
      err_q  <= err_d;
      last_q <= last;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.byte_valid  = bvld_q;
  assign out_o.error_code  = err_q;
  assign out_o.last_of_run = last_q;

endmodule

FILE: dv/tb_utf8_to_json_string_escaper_core.sv
`timescale 1ns / 1ps
// Testbench for utf8_to_json_string_escaper_core: random and directed UTF-8 strings,
// bursty sender, stalling receiver, output checked word by word against a local escaper.
// Depends on u8js_pkg, u8js_in_if, u8js_out_if and the core.
module tb_utf8_to_json_string_escaper_core;
  import u8js_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomWords   = 280;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    err_e       error_code;
    logic       last_of_run;
  } json_word_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_BURSTY,
    RX_TOGGLE
  } rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  u8js_in_if  in_if ();
  u8js_out_if out_if ();

  utf8_to_json_string_escaper_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  item_t      byte_items[$];
  logic [7:0] string_bytes[$];
  json_word_t escaped_due[$];
  item_t      on_bus;

  logic [20:0] dec_code;
  logic [1:0]  dec_left;
  logic [1:0]  dec_len;

  int stim_count;
  int words_in;
  int words_out;
  int err_reports;
  int fails;
  int idle_cycles;

  // ---------------------------------------------------------------- escaper
  function automatic void put_word(logic [7:0] b, logic v, err_e e);
    json_word_t w;
    w.out_byte    = b;
    w.byte_valid  = v;
    w.error_code  = e;
    w.last_of_run = 1'b0;
    escaped_due.push_back(w);
  endfunction

  function automatic void put_hex4(logic [15:0] v);
    logic [3:0] nib;
    put_word(ChBackslash, 1'b1, ERR_NONE);
    put_word(ChU, 1'b1, ERR_NONE);
    for (int s = 12; s >= 0; s -= 4) begin
      nib = v[s+:4];
      put_word((nib < 4'd10) ? ChZero + 8'(nib) : ChLowerA + 8'(nib) - 8'd10, 1'b1, ERR_NONE);
    end
  endfunction

  function automatic void put_char(logic [20:0] code);
    logic [20:0] off;
    if (code >= CodeMin4) begin
      off = code - CodeMin4;
      put_hex4({SurrHiPrefix, off[19:10]});
      put_hex4({SurrLoPrefix, code[9:0]});
    end else if (code == 21'(ChQuote) || code == 21'(ChBackslash)) begin
      put_word(ChBackslash, 1'b1, ERR_NONE);
      put_word(code[7:0], 1'b1, ERR_NONE);
    end else if (code <= CodeCtrlMax || code >= CodeDel) begin
      put_hex4(code[15:0]);
    end else begin
      put_word(code[7:0], 1'b1, ERR_NONE);
    end
  endfunction

  function automatic void drop_pending();
    dec_code = '0;
    dec_left = '0;
    dec_len  = '0;
  endfunction

  function automatic void take_lead(logic [7:0] b);
    if (b < 8'h80) begin
      put_char({13'd0, b});
    end else if (b < LeadMin2 || b >= LeadEnd) begin
      put_word(8'h00, 1'b0, ERR_LEAD);
    end else if (b < LeadMin3) begin
      dec_code = {16'd0, b[4:0]};
      dec_left = 2'd1;
      dec_len  = 2'd1;
    end else if (b < LeadMin4) begin
      dec_code = {17'd0, b[3:0]};
      dec_left = 2'd2;
      dec_len  = 2'd2;
    end else begin
      dec_code = {18'd0, b[2:0]};
      dec_left = 2'd3;
      dec_len  = 2'd3;
    end
  endfunction

  function automatic void escape_word(item_t it);
    int n0;
    n0 = escaped_due.size();
    if (it.first_of_string) begin
      if (dec_left != 0) begin
        put_word(8'h00, 1'b0, ERR_TRUNC);
        drop_pending();
      end
      put_word(ChQuote, 1'b1, ERR_NONE);
    end
    if (it.has_byte) begin
      if (dec_left == 0) begin
        take_lead(it.in_byte);
      end else if (it.in_byte[7:6] != 2'b10) begin
        put_word(8'h00, 1'b0, ERR_CONT);
        drop_pending();
        take_lead(it.in_byte);
      end else begin
        dec_code = {dec_code[14:0], it.in_byte[5:0]};
        dec_left = dec_left - 2'd1;
        if (dec_left == 0) begin
          if ((dec_len == 2'd2 && dec_code < CodeMin3) ||
              (dec_len == 2'd3 && dec_code < CodeMin4)) begin
            put_word(8'h00, 1'b0, ERR_OVERLONG);
          end else if (dec_code > CodeMax || (dec_code >= SurrFirst && dec_code < SurrEnd)) begin
            put_word(8'h00, 1'b0, ERR_RANGE);
          end else begin
            put_char(dec_code);
          end
          drop_pending();
        end
      end
    end
    if (it.last_of_string) begin
      if (dec_left != 0) begin
        put_word(8'h00, 1'b0, ERR_TRUNC);
        drop_pending();
      end
      put_word(ChQuote, 1'b1, ERR_NONE);
    end
    if (escaped_due.size() > n0) begin
      escaped_due[escaped_due.size()-1].last_of_run = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic add_item(logic [7:0] b, logic has, logic first, logic last);
    item_t it;
    it.in_byte         = b;
    it.has_byte        = has;
    it.first_of_string = first;
    it.last_of_string  = last;
    byte_items.push_back(it);
    if (has || first || last) begin
      stim_count++;
    end
  endtask

  task automatic emit_string(bit open_sep, bit close_sep, bit do_close);
    int n;
    n = string_bytes.size();
    if (n == 0) begin
      open_sep  = 1'b1;
      close_sep = 1'b1;
    end
    if (open_sep) begin
      add_item(8'($urandom), 1'b0, 1'b1, 1'b0);
    end
    for (int i = 0; i < n; i++) begin
      add_item(string_bytes[i], 1'b1, !open_sep && i == 0,
               do_close && !close_sep && i == n - 1);
    end
    if (do_close && close_sep) begin
      add_item(8'($urandom), 1'b0, 1'b0, 1'b1);
    end
  endtask

  task automatic add_random_char();
    int          pick;
    int          nb;
    int          cut;
    logic [20:0] code;
    pick = $urandom_range(0, 15);
    nb   = 1;
    cut  = 0;
    code = '0;
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0:       code = 21'(ChQuote);
          1:       code = 21'(ChBackslash);
          2:       code = CodeDel;
          default: code = 21'($urandom_range(0, 31));
        endcase
      end
      1, 2, 3, 4: code = 21'($urandom_range(0, 127));
      5, 6: begin
        nb   = 2;
        code = 21'($urandom_range(21'h80, 21'h7ff));
      end
      7, 8: begin
        nb   = 3;
        code = 21'($urandom_range(21'h800, 21'hffff));
      end
      9, 10: begin
        nb   = 4;
        code = 21'($urandom_range(21'h10000, 21'h10ffff));
      end
      11: begin
        // overlong forms
        nb   = $urandom_range(2, 4);
        code = 21'($urandom_range(0, (nb == 2) ? 21'h7f :
                                     (nb == 3) ? 21'h7ff : 21'hffff));
      end
      12: begin
        if ($urandom_range(0, 1)) begin
          nb   = 3;
          code = 21'($urandom_range(21'hd800, 21'hdfff));
        end else begin
          nb   = 4;
          code = 21'($urandom_range(21'h110000, 21'h1fffff));
        end
      end
      13: begin
        // sequence cut short
        nb   = $urandom_range(3, 4);
        code = (nb == 3) ? 21'($urandom_range(21'h800, 21'hd7ff))
                         : 21'($urandom_range(21'h10000, 21'h10ffff));
        cut  = $urandom_range(1, nb - 1);
      end
      14: begin
        nb = 0;
        string_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        nb = 0;
        string_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
    endcase
    case (nb)
      1: string_bytes.push_back(code[7:0]);
      2: begin
        string_bytes.push_back({3'b110, code[10:6]});
        string_bytes.push_back({2'b10, code[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, code[15:12]});
        string_bytes.push_back({2'b10, code[11:6]});
        string_bytes.push_back({2'b10, code[5:0]});
      end
      4: begin
        string_bytes.push_back({5'b11110, code[20:18]});
        string_bytes.push_back({2'b10, code[17:12]});
        string_bytes.push_back({2'b10, code[11:6]});
        string_bytes.push_back({2'b10, code[5:0]});
      end
      default: ;
    endcase
    repeat (cut) void'(string_bytes.pop_back());
  endtask

  task automatic add_random_string();
    int nchars;
    string_bytes.delete();
    nchars = $urandom_range(0, 6);
    repeat (nchars) add_random_char();
    if ($urandom_range(0, 5) == 0) begin
      string_bytes.push_back(8'($urandom_range(LeadMin2, LeadEnd - 8'd1)));
    end
    if (string_bytes.size() == 0 && $urandom_range(0, 1)) begin
      add_item(8'($urandom), 1'b0, 1'b1, 1'b1);
    end else begin
      emit_string($urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                  $urandom_range(0, 11) != 0);
    end
    if ($urandom_range(0, 9) == 0) begin
      add_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------- driver
  int burst_left;
  int gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid           <= 1'b0;
      in_if.in_byte         <= '0;
      in_if.has_byte        <= 1'b0;
      in_if.first_of_string <= 1'b0;
      in_if.last_of_string  <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        escape_word(on_bus);
        words_in++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (byte_items.size() > 0) begin
          on_bus = byte_items.pop_front();
          in_if.valid           <= 1'b1;
          in_if.in_byte         <= on_bus.in_byte;
          in_if.has_byte        <= on_bus.has_byte;
          in_if.first_of_string <= on_bus.first_of_string;
          in_if.last_of_string  <= on_bus.last_of_string;
          burst_left--;
          if (burst_left <= 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  rx_mode_e rx_mode;
  int       rx_mode_left;
  int       rx_stall_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode       = RX_OPEN;
      rx_mode_left  = 0;
      rx_stall_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 80);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
        RX_BURSTY: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            out_if.ready <= 1'b0;
          end else begin
            rx_stall_left = $urandom_range(0, 7);
            out_if.ready <= 1'b1;
          end
        end
        default:   out_if.ready <= !out_if.ready;
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    json_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      words_out++;
      if (!out_if.byte_valid) begin
        err_reports++;
      end
      if (escaped_due.size() == 0) begin
        fails++;
        if (fails <= 10) begin
          $display("unexpected word: byte %02h valid %0d err %0d last %0d",
                   out_if.out_byte, out_if.byte_valid, out_if.error_code,
                   out_if.last_of_run);
        end
      end else begin
        w = escaped_due.pop_front();
        if (out_if.out_byte !== w.out_byte || out_if.byte_valid !== w.byte_valid ||
            out_if.error_code !== w.error_code || out_if.last_of_run !== w.last_of_run) begin
          fails++;
          if (fails <= 10) begin
            $display({"mismatch at word %0d: expected byte %02h valid %0d err %0d last %0d,",
                      " got byte %02h valid %0d err %0d last %0d"},
                     words_out, w.out_byte, w.byte_valid, w.error_code, w.last_of_run,
                     out_if.out_byte, out_if.byte_valid, out_if.error_code,
                     out_if.last_of_run);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no word moved for %0d cycles", WatchdogLimit);
        $display("tb_utf8_to_json_string_escaper_core: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.in_byte         = '0;
    in_if.has_byte        = 1'b0;
    in_if.first_of_string = 1'b0;
    in_if.last_of_string  = 1'b0;
    out_if.ready          = 1'b0;
    stim_count  = 0;
    words_in    = 0;
    words_out   = 0;
    err_reports = 0;
    fails       = 0;
    idle_cycles = 0;
    drop_pending();

    // empty string, word with nothing to emit
    add_item(8'($urandom), 1'b0, 1'b1, 1'b1);
    add_item(8'($urandom), 1'b0, 1'b0, 1'b0);
    // escapes, controls, 2- and 4-byte forms, overlong 3-byte, surrogate, too large,
    // bad lead, bad continuation, truncated at close
    string_bytes = '{8'h22, 8'h5c, 8'h00, 8'h7f, 8'hc2, 8'h80, 8'he0, 8'h80, 8'h80,
                     8'hed, 8'ha0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hf4, 8'h90,
                     8'h80, 8'h80, 8'hff, 8'hc3, 8'h41, 8'he2, 8'h82};
    emit_string(1'b0, 1'b0, 1'b1);
    // string reopened while a character is pending
    string_bytes = '{8'hc3};
    emit_string(1'b0, 1'b0, 1'b0);
    add_item(8'h41, 1'b1, 1'b1, 1'b1);

    while (stim_count < RandomWords) begin
      add_random_string();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (byte_items.size() != 0 || in_if.valid || escaped_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);

    $display("run covered %0d input words and %0d output words, %0d of them error reports",
             words_in, words_out, err_reports);
    $display("%0d mismatches", fails);
    if (fails == 0) begin
      $display("tb_utf8_to_json_string_escaper_core: PASS");
    end else begin
      $display("tb_utf8_to_json_string_escaper_core: FAIL");
    end
    $finish;
  end

endmodule
